// ===== sv/wellp_pkg.sv =====
// Shared types and constants for the dual-lane WELL512a generator.
// No dependencies; used by the cell, mix and top-level modules.
package wellp_pkg;

  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned PTR_W     = 4;
  localparam int unsigned WORD_W    = 64;

  // Fixed taps relative to the current word
  localparam int unsigned TAP_M1 = 13;
  localparam int unsigned TAP_M2 = 9;

  localparam logic [WORD_W-1:0] MASK_SH16 = 64'hFFFF0000FFFF0000;
  localparam logic [WORD_W-1:0] MASK_SH15 = 64'hFFFF8000FFFF8000;
  localparam logic [WORD_W-1:0] MASK_SR11 = 64'h001FFFFF001FFFFF;
  localparam logic [WORD_W-1:0] MASK_SH5  = 64'hFFFFFFE0FFFFFFE0;
  localparam logic [WORD_W-1:0] MIX_CONST = 64'hDA442D24DA442D24;
  localparam logic [WORD_W-1:0] MASK_SH2  = 64'hFFFFFFFCFFFFFFFC;
  localparam logic [WORD_W-1:0] MASK_SH18 = 64'hFFFC0000FFFC0000;
  localparam logic [WORD_W-1:0] MASK_SH28 = 64'hF0000000F0000000;

  typedef enum logic {
    OP_GEN  = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Per-cell control: all cells shift together on gen or rot
  typedef struct packed {
    logic gen;
    logic rot;
    logic load;
  } cell_ctl_t;

endpackage

// ===== sv/wellp_cell.sv =====
// One 64-bit word of the state ring.
// Depends on wellp_pkg for word width and the control struct.
module wellp_cell
  import wellp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] gen_in,
  input  logic [WORD_W-1:0] next_in,
  input  logic [WORD_W-1:0] load_val,
  output logic [WORD_W-1:0] word
);

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctl.load) begin
      word <= load_val;
    end else if (ctl.gen) begin
      word <= gen_in;
    end else if (ctl.rot) begin
      word <= next_in;
    end
  end

endmodule

// ===== sv/wellp_mix.sv =====
// WELL512a recurrence on two packed 32-bit lanes; pure combinational.
// Depends on wellp_pkg for the lane masks.
module wellp_mix
  import wellp_pkg::*;
(
  input  logic [WORD_W-1:0] s0,
  input  logic [WORD_W-1:0] s13,
  input  logic [WORD_W-1:0] s9,
  input  logic [WORD_W-1:0] prev,
  output logic [WORD_W-1:0] nv,
  output logic [WORD_W-1:0] res
);

  logic [WORD_W-1:0] z1;
  logic [WORD_W-1:0] z2;
  logic [WORD_W-1:0] mix;

  // Masks drop bits crossing between the two 32-bit lanes
  assign z1  = s0 ^ ((s0 << 16) & MASK_SH16) ^ s13 ^ ((s13 << 15) & MASK_SH15);
  assign z2  = s9 ^ ((s9 >> 11) & MASK_SR11);
  assign nv  = z1 ^ z2;
  assign mix = nv ^ (((nv << 5) & MASK_SH5) & MIX_CONST);
  assign res = prev ^ ((prev << 2) & MASK_SH2)
             ^ z1 ^ ((z1 << 18) & MASK_SH18)
             ^ ((z2 << 28) & MASK_SH28)
             ^ mix;

endmodule

// ===== sv/well512_dual_lane_prng.sv =====
// Dual-lane WELL512a generator: each 64-bit result carries two independent 32-bit
// generators, one per half. The 16-word state sits in a ring of cells that shifts by one
// word per generate item, so the taps are fixed wires and a generate item, like a load
// into an aligned ring, is accepted every cycle unless stalled. A load writes one word and
// resets the logical pointer to zero, which the ring then catches up with by rotating one
// word per cycle with in_stall high, so the item after a load waits for alignment. Results
// sit in an output register, so a new item is taken in the cycle the previous result
// leaves. Reset clears the state to zero; an all-zero state produces only zeros.
module well512_dual_lane_prng
  import wellp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [PTR_W-1:0]  word_slot,
  input  logic [WORD_W-1:0] word_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] random_value
);

  logic [WORD_W-1:0] words [POOL_SIZE];
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  off;
  logic [PTR_W-1:0]  load_idx;
  logic              aligned;
  logic              in_fire;
  logic              gen_fire;
  logic              load_fire;
  logic [WORD_W-1:0] nv;
  logic [WORD_W-1:0] res;

  assign aligned   = (off == ptr);
  assign in_stall  = !aligned || (out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign gen_fire  = in_fire && (op == OP_GEN);
  assign load_fire = in_fire && (op == OP_LOAD);
  // Cell k holds logical word (off + k)
  assign load_idx  = word_slot - off;

  wellp_mix u_mix (
    .s0   (words[0]),
    .s13  (words[TAP_M1]),
    .s9   (words[TAP_M2]),
    .prev (words[POOL_SIZE-1]),
    .nv   (nv),
    .res  (res)
  );

  for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
    localparam int unsigned NXT = (k + 1) % POOL_SIZE;
    logic [WORD_W-1:0] gin;
    cell_ctl_t         ctl;

    if (k == 0) begin : g_head
      assign gin = res;
    end else if (k == 1) begin : g_new
      assign gin = nv;
    end else begin : g_shift
      assign gin = words[k-1];
    end

    assign ctl.gen  = gen_fire;
    assign ctl.rot  = !aligned;
    assign ctl.load = load_fire && (load_idx == PTR_W'(k));

    wellp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .gen_in   (gin),
      .next_in  (words[NXT]),
      .load_val (word_value),
      .word     (words[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      off <= '0;
    end else if (load_fire) begin
      ptr <= '0;
    end else if (gen_fire) begin
      ptr <= ptr - 1'b1;
      off <= off - 1'b1;
    end else if (!aligned) begin
      off <= off + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      random_value <= res;
    end
  end

  a_gen_aligned: assert property (@(posedge clk) disable iff (rst)
    gen_fire |-> (off == ptr))
    else $error("generate item taken with ring misaligned");

  a_gen_result: assert property (@(posedge clk) disable iff (rst)
    gen_fire |=> (out_valid && random_value == $past(res)))
    else $error("generate item did not produce a result");

  a_load_ptr: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> (ptr == '0 && !$rose(out_valid)))
    else $error("load item did not clear pointer or produced a result");

  a_rot_idle: assert property (@(posedge clk) disable iff (rst)
    !aligned |=> (off == $past(off) + 1'b1) && $stable(ptr))
    else $error("ring rotation stepped wrongly");

endmodule

// ===== tb/tb_well512_dual_lane_prng.sv =====
// Testbench for the dual-lane WELL512a generator: directed and random load/generate items,
// with random gaps on the input and output side. Results are checked against a local
// model of the pool. Depends on wellp_pkg and well512_dual_lane_prng.
module tb_well512_dual_lane_prng;
  import wellp_pkg::*;

  localparam int GAP_MAX     = 12;
  localparam int IDLE_LIMIT  = 400;
  localparam int DRAIN_WAIT  = 32;
  localparam int RANDOM_ITEMS = 1100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = OP_GEN;
  logic [PTR_W-1:0]  word_slot = '0;
  logic [WORD_W-1:0] word_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] random_value;

  // shadow copy of the pool
  logic [WORD_W-1:0] pool_copy [POOL_SIZE];
  logic [PTR_W-1:0]  pool_ptr_copy;
  logic [WORD_W-1:0] pending_words [$];

  int  error_count = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  burst_mode = 1'b0;

  well512_dual_lane_prng u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .word_slot    (word_slot),
    .word_value   (word_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the shadow pool by one item; a generate item queues the word it produces.
  task automatic advance_pool(input logic is_load, input logic [PTR_W-1:0] slot,
                              input logic [WORD_W-1:0] value);
    logic [PTR_W-1:0]  p;
    logic [WORD_W-1:0] w0, w13, w9, z1, z2, nv, prev, mix, fresh;
    if (is_load) begin
      pool_copy[slot] = value;
      pool_ptr_copy = '0;
    end else begin
      p   = pool_ptr_copy;
      w0  = pool_copy[p];
      w13 = pool_copy[PTR_W'(p + TAP_M1)];
      w9  = pool_copy[PTR_W'(p + TAP_M2)];
      z1  = w0 ^ ((w0 << 16) & MASK_SH16) ^ w13 ^ ((w13 << 15) & MASK_SH15);
      z2  = w9 ^ ((w9 >> 11) & MASK_SR11);
      nv  = z1 ^ z2;
      pool_copy[p] = nv;
      p = p - 1'b1;
      pool_ptr_copy = p;
      prev = pool_copy[p];
      mix = nv ^ (((nv << 5) & MASK_SH5) & MIX_CONST);
      fresh = prev ^ ((prev << 2) & MASK_SH2) ^ z1 ^ ((z1 << 18) & MASK_SH18)
            ^ ((z2 << 28) & MASK_SH28) ^ mix;
      pool_copy[p] = fresh;
      pending_words.push_back(fresh);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) pool_copy[i] = '0;
    pool_ptr_copy = '0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      advance_pool(op == OP_LOAD, word_slot, word_value);
  end

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, random_value);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (random_value !== want) begin
          $display("%0t: random_value mismatch, expected %h, actual %h",
                   $time, want, random_value);
          error_count++;
        end
      end
    end
  end

  // Output side: one stall draw per result.
  initial begin
    int n;
    forever begin
      n = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input op_t kind, input logic [PTR_W-1:0] slot,
                           input logic [WORD_W-1:0] value);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= kind;
    word_slot  <= slot;
    word_value <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '1;
    if (pick == 1) return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
    return {$urandom, $urandom};
  endfunction

  // Pool is zero after reset, so generated words stay zero; fields are ignored.
  task automatic test_zero_pool();
    send_item(OP_GEN, 4'd15, '1);
    send_item(OP_GEN, 4'd0, '0);
  endtask

  task automatic test_field_extremes();
    send_item(OP_LOAD, 4'd0, '1);
    send_item(OP_LOAD, 4'd15, 64'h5555_5555_5555_5555);
    send_item(OP_LOAD, 4'd13, '1);
    send_item(OP_LOAD, 4'd9, 64'h0000_0000_0000_0001);
    // first generate wraps the pointer from 0 to 15
    repeat (4) send_item(OP_GEN, 4'd15, '1);
  endtask

  // A load in the middle of a run must bring the pointer back to zero.
  task automatic test_pointer_clear();
    send_item(OP_GEN, 4'd3, random_word());
    send_item(OP_GEN, 4'd7, random_word());
    send_item(OP_LOAD, 4'd15, 64'h8000_0000_8000_0000);
    send_item(OP_GEN, 4'd0, random_word());
    send_item(OP_GEN, 4'd0, random_word());
  endtask

  task automatic test_random_stream();
    int target;
    int kind;
    int run_len;
    int j;
    logic [PTR_W-1:0] order [POOL_SIZE];
    logic [PTR_W-1:0] tmp;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // full reseed in shuffled slot order
        for (int i = 0; i < POOL_SIZE; i++) order[i] = PTR_W'(i);
        for (int i = POOL_SIZE - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < POOL_SIZE; i++) send_item(OP_LOAD, order[i], random_word());
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4))
          send_item(OP_LOAD, PTR_W'($urandom_range(0, POOL_SIZE - 1)), random_word());
      end
      run_len = $urandom_range(1, 48);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(OP_LOAD, PTR_W'($urandom_range(0, POOL_SIZE - 1)), random_word());
        else
          send_item(OP_GEN, PTR_W'($urandom_range(0, POOL_SIZE - 1)), random_word());
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_pool();
    test_field_extremes();
    test_pointer_clear();
    test_random_stream();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
